// ===== rtl/tvs_pkg.sv =====
// shared types and constants for the trilinear volume sampler
package tvs_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_ORIGIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_INV_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_INV_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_INV_LEN = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_CHECK,
    ST_READ,
    ST_LERP,
    ST_DONE
  } tvs_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       clr_write;  // write zero at the clear address
    logic       clr_step;   // advance the clear address
    logic       load;       // capture the input item
    logic       do_write;   // store the captured sample
    logic       map;        // scale the coordinates
    logic       check;      // compute floors and range
    logic       rd_issue;   // issue a corner read
    logic       lerp;       // run one lerp step
    logic       out_load;   // load the result register
  } tvs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic oor;
    logic rd_last;
    logic lerp_last;
    logic out_full;
  } tvs_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    else if (v < -50'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== rtl/tvs_ram.sv =====
// generic single-port ram with registered read
module tvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/tvs_ctrl.sv =====
// sequencing state machine for the trilinear volume sampler
module tvs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tvs_pkg::tvs_stat_t stat,
  output tvs_pkg::tvs_cmd_t  cmd
);
  import tvs_pkg::*;

  tvs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        cmd.clr_step  = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (!stat.is_query) begin
          cmd.do_write = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.map    = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        if (stat.oor) begin
          state_next = ST_DONE;
        end else begin
          cmd.rd_issue = 1'b1;
          if (stat.rd_last) state_next = ST_LERP;
        end
      end
      ST_LERP: begin
        cmd.lerp = 1'b1;
        if (stat.lerp_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_full)
    else $error("result loaded over a pending result");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("input taken during clear");
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_MAP))
    else $error("load did not start work");
endmodule

// ===== rtl/tvs_datapath.sv =====
// lattice memory, coordinate mapping and lerp datapath
module tvs_datapath #(
  parameter int unsigned X_SIZE = 32,
  parameter int unsigned Y_SIZE = 32,
  parameter int unsigned Z_SIZE = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tvs_pkg::tvs_cmd_t        cmd,
  output tvs_pkg::tvs_stat_t       stat,
  input  logic                     operation,
  input  logic [4:0]               index_x,
  input  logic [4:0]               index_y,
  input  logic [4:0]               index_z,
  input  logic signed [31:0]       sample_value,
  input  logic signed [31:0]       coord_x,
  input  logic signed [31:0]       coord_y,
  input  logic signed [31:0]       coord_z,
  input  logic signed [31:0]       x_origin,
  input  logic signed [31:0]       y_origin,
  input  logic signed [31:0]       z_origin,
  input  logic [23:0]              x_inv_len,
  input  logic [23:0]              y_inv_len,
  input  logic [23:0]              z_inv_len,
  input  logic                     out_take,
  output logic                     out_valid,
  output logic signed [31:0]       interp_value,
  output logic                     out_of_range
);
  import tvs_pkg::*;

  localparam int unsigned XW = $clog2(X_SIZE);
  localparam int unsigned YW = $clog2(Y_SIZE);
  localparam int unsigned ZW = $clog2(Z_SIZE);
  localparam int unsigned AW = XW + YW + ZW;
  // address is the concatenation of the axis fields, so the store spans all of it
  localparam int unsigned DEPTH = 1 << AW;

  // captured item
  logic              op;
  logic [4:0]        ix, iy, iz;
  logic signed [31:0] sval;
  logic signed [31:0] cx, cy, cz;

  // mapped coordinates, 41 bits holds scaled minus origin
  logic signed [56:0] px, py, pz;
  logic signed [40:0] vx, vy, vz;
  logic [24:0]        flx, fly, flz;  // integer parts
  logic [15:0]        fx, fy, fz;
  logic               oor;

  logic [AW:0]        clr_addr;
  logic [2:0]         rd_cnt;
  logic               rd_pend;
  logic [2:0]         wr_idx;
  logic signed [31:0] corner [8];
  logic [2:0]         lerp_cnt;
  logic signed [31:0] res;

  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [31:0]        ram_wdata, ram_rdata;

  // input item capture and scaling products, both registered
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation; ix <= index_x; iy <= index_y; iz <= index_z;
      sval <= sample_value; cx <= coord_x; cy <= coord_y; cz <= coord_z;
    end
    if (cmd.map) begin
      px <= 57'(cx) * $signed({1'b0, x_inv_len});
      py <= 57'(cy) * $signed({1'b0, y_inv_len});
      pz <= 57'(cz) * $signed({1'b0, z_inv_len});
    end
  end

  // floor shift then subtract origin
  assign vx = 41'(px >>> FRAC_W) - 41'(x_origin);
  assign vy = 41'(py >>> FRAC_W) - 41'(y_origin);
  assign vz = 41'(pz >>> FRAC_W) - 41'(z_origin);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      fx <= vx[15:0]; fy <= vy[15:0]; fz <= vz[15:0];
      flx <= vx[40:16]; fly <= vy[40:16]; flz <= vz[40:16];
      oor <= vx[40] || vy[40] || vz[40]
          || (vx[40:16] >= 25'(X_SIZE - 1))
          || (vy[40:16] >= 25'(Y_SIZE - 1))
          || (vz[40:16] >= 25'(Z_SIZE - 1));
    end
  end

  // clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // corner reads: bit2 = x, bit1 = y, bit0 = z
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  logic [ZW-1:0] az;
  always_comb begin
    ax = XW'(flx) + XW'(rd_cnt[2]);
    ay = YW'(fly) + YW'(rd_cnt[1]);
    az = ZW'(flz) + ZW'(rd_cnt[0]);
  end

  logic wr_ok;
  assign wr_ok = (32'(ix) < X_SIZE) && (32'(iy) < Y_SIZE) && (32'(iz) < Z_SIZE);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = {ax, ay, az};
    if (cmd.clr_write) begin
      ram_we   = 1'b1;
      ram_addr = clr_addr[AW-1:0];
    end else if (cmd.do_write) begin
      ram_we    = wr_ok;
      ram_wdata = sval;
      ram_addr  = {XW'(ix), YW'(iy), ZW'(iz)};
    end
  end

  tvs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt  <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
      if (cmd.rd_issue) rd_cnt <= rd_cnt + 1'b1;
    end
    wr_idx <= rd_cnt;
    if (rd_pend) corner[wr_idx] <= ram_rdata;
  end

  // lerp unit: one step per cycle, operands chosen by step count
  // steps 0..3 lerp z pairs, 4..5 y, 6 x; the last read lands in step 0
  logic signed [31:0] la, lb, lr;
  logic [15:0]        lf;
  logic signed [49:0] pa, pb;
  logic signed [31:0] acc [4];
  logic signed [31:0] ca, cb;

  always_comb begin
    ca = (rd_pend && wr_idx == 3'(2*lerp_cnt[1:0]+1)) ? ram_rdata
       : corner[3'(2*lerp_cnt[1:0])];
    cb = (rd_pend && wr_idx == 3'(2*lerp_cnt[1:0]+1)) ? ram_rdata
       : corner[3'(2*lerp_cnt[1:0]+1)];
    unique case (lerp_cnt)
      3'd4:    begin la = acc[0]; lb = acc[1]; lf = fy; end
      3'd5:    begin la = acc[2]; lb = acc[3]; lf = fy; end
      3'd6:    begin la = acc[0]; lb = acc[1]; lf = fx; end
      default: begin
        la = corner[3'(2*lerp_cnt[1:0])];
        lb = cb;
        lf = fz;
      end
    endcase
    pa = 50'(la) * $signed({1'b0, 17'(32'd65536 - 32'(lf))});
    pb = 50'(lb) * $signed({1'b0, 17'(lf)});
    lr = sat32((pa >>> FRAC_W) + (pb >>> FRAC_W));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lerp_cnt <= '0;
    end else if (cmd.lerp) begin
      lerp_cnt <= (lerp_cnt == 3'd6) ? 3'd0 : lerp_cnt + 1'b1;
    end
    if (cmd.lerp) begin
      unique case (lerp_cnt)
        3'd4:    acc[0] <= lr;
        3'd5:    acc[1] <= lr;
        3'd6:    res    <= lr;
        default: acc[lerp_cnt[1:0]] <= lr;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      interp_value <= oor ? 32'sd0 : res;
      out_of_range <= oor;
    end
  end

  assign stat.clr_last  = (clr_addr[AW-1:0] == AW'(DEPTH - 1));
  assign stat.is_query  = (op == OP_QUERY);
  assign stat.oor       = oor;
  assign stat.rd_last   = (rd_cnt == 3'd7);
  assign stat.lerp_last = (lerp_cnt == 3'd6);
  assign stat.out_full  = out_valid && !out_take;

  logic unused;
  assign unused = ^{ca, clr_addr[AW]};

  assert property (@(posedge clk) disable iff (rst)
    cmd.lerp && (lerp_cnt == 3'd0) |-> $past(rd_pend))
    else $error("lerp began before corners arrived");
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> !oor)
    else $error("corner read for a cell outside the lattice");
endmodule

// ===== rtl/trilinear_volume_sampler.sv =====
// top level of the trilinear volume sampler
// after reset a clearing pass zeroes every lattice address, one per cycle, no items taken
// a write item is stored in ST_MAP, then the controller returns to ST_IDLE, ready again
// a query goes through scale, floor, 8 corner reads through the single lattice port,
// 7 lerp steps and the result register; the next item is taken only after the result is
// loaded, which waits while an earlier result is still held by out_stall
// an out-of-range query skips reads and lerps; config regs reset to 0 and 1.0
module trilinear_volume_sampler #(
  parameter int unsigned X_SIZE = 32,
  parameter int unsigned Y_SIZE = 32,
  parameter int unsigned Z_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst,
  // input item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [4:0]        index_x,
  input  logic [4:0]        index_y,
  input  logic [4:0]        index_z,
  input  logic signed [31:0] sample_value,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  // result item channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] interp_value,
  output logic              out_of_range,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import tvs_pkg::*;

  tvs_cmd_t  cmd;
  tvs_stat_t stat;

  logic signed [31:0] x_origin, y_origin, z_origin;
  logic [23:0]        x_inv_len, y_inv_len, z_inv_len;

  // config registers, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin  <= '0;
      y_origin  <= '0;
      z_origin  <= '0;
      x_inv_len <= 24'd65536;
      y_inv_len <= 24'd65536;
      z_inv_len <= 24'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_ORIGIN:  x_origin  <= cfg_data;
        REG_Y_ORIGIN:  y_origin  <= cfg_data;
        REG_Z_ORIGIN:  z_origin  <= cfg_data;
        REG_X_INV_LEN: x_inv_len <= cfg_data[23:0];
        REG_Y_INV_LEN: y_inv_len <= cfg_data[23:0];
        REG_Z_INV_LEN: z_inv_len <= cfg_data[23:0];
        default: ; // index beyond the list is dropped
      endcase
    end
  end

  tvs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  tvs_datapath #(.X_SIZE(X_SIZE), .Y_SIZE(Y_SIZE), .Z_SIZE(Z_SIZE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .operation(operation), .index_x(index_x), .index_y(index_y), .index_z(index_z),
    .sample_value(sample_value), .coord_x(coord_x), .coord_y(coord_y),
    .coord_z(coord_z),
    .x_origin(x_origin), .y_origin(y_origin), .z_origin(z_origin),
    .x_inv_len(x_inv_len), .y_inv_len(y_inv_len), .z_inv_len(z_inv_len),
    .out_take(!out_stall), .out_valid(out_valid),
    .interp_value(interp_value), .out_of_range(out_of_range)
  );
endmodule

// ===== dv/trilinear_volume_sampler_tb.sv =====
// testbench for the trilinear volume sampler: directed and random items against a local predictor
module trilinear_volume_sampler_tb;
  import tvs_pkg::*;

  localparam int XS = 32;
  localparam int YS = 32;
  localparam int ZS = 32;
  localparam int CELLS = XS * YS * ZS;
  // the idle limit has to cover the whole clearing pass, so it is scaled from CELLS
  localparam int IDLE_LIMIT = 3 * CELLS + 2000;

  typedef struct {
    logic              op;
    logic [4:0]        ix, iy, iz;
    logic signed [31:0] sval;
    logic signed [31:0] cx, cy, cz;
  } vol_item_t;

  typedef struct {
    logic signed [31:0] val;
    logic              oor;
  } vol_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              operation = OP_WRITE;
  logic [4:0]        index_x = '0, index_y = '0, index_z = '0;
  logic signed [31:0] sample_value = '0, coord_x = '0, coord_y = '0, coord_z = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [31:0] interp_value;
  logic              out_of_range;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [31:0]       cfg_data = '0;

  trilinear_volume_sampler #(.X_SIZE(XS), .Y_SIZE(YS), .Z_SIZE(ZS)) dut (.*);

  always #5 clk = ~clk;

  // predictor state: lattice copy and register copies
  logic signed [31:0] shadow_lattice [CELLS];
  logic signed [31:0] origin_q [3];
  logic [23:0]        inv_len_q [3];

  vol_item_t   pending_items [$];
  vol_result_t expected_results [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          hold_sender = 1'b0;

  // floor division by 2^16, exact for negative values
  function automatic longint floor16(input longint p);
    return p >>> 16;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint f);
    return clamp32(floor16(a * (65536 - f)) + floor16(b * f));
  endfunction

  function automatic longint corner(input longint x, input longint y, input longint z);
    longint addr;
    addr = (x * YS + y) * ZS + z;
    if (addr < 0 || addr >= CELLS) return 0;
    return shadow_lattice[addr];
  endfunction

  // applies one item to the shadow state; queues its result if it has one
  function automatic void predict_sample(input vol_item_t it);
    longint coord [3];
    longint size [3];
    longint cell_idx [3];
    longint frac [3];
    longint v, i1, i2, j1, j2, w1, w2;
    bit ok;
    vol_result_t r;
    if (it.op == OP_WRITE) begin
      shadow_lattice[(int'(it.ix) * YS + int'(it.iy)) * ZS + int'(it.iz)] = it.sval;
      return;
    end
    coord[0] = it.cx; coord[1] = it.cy; coord[2] = it.cz;
    size[0] = XS; size[1] = YS; size[2] = ZS;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      v = floor16(coord[a] * longint'(inv_len_q[a])) - longint'(origin_q[a]);
      cell_idx[a] = floor16(v);
      frac[a] = v - cell_idx[a] * 65536;
      if (cell_idx[a] < 0 || cell_idx[a] >= size[a] - 1) ok = 1'b0;
    end
    if (!ok) begin
      r.val = '0;
      r.oor = 1'b1;
    end else begin
      i1 = blend(corner(cell_idx[0], cell_idx[1], cell_idx[2]),
                 corner(cell_idx[0], cell_idx[1], cell_idx[2]+1), frac[2]);
      i2 = blend(corner(cell_idx[0], cell_idx[1]+1, cell_idx[2]),
                 corner(cell_idx[0], cell_idx[1]+1, cell_idx[2]+1), frac[2]);
      j1 = blend(corner(cell_idx[0]+1, cell_idx[1], cell_idx[2]),
                 corner(cell_idx[0]+1, cell_idx[1], cell_idx[2]+1), frac[2]);
      j2 = blend(corner(cell_idx[0]+1, cell_idx[1]+1, cell_idx[2]),
                 corner(cell_idx[0]+1, cell_idx[1]+1, cell_idx[2]+1), frac[2]);
      w1 = blend(i1, i2, frac[1]);
      w2 = blend(j1, j2, frac[1]);
      r.val = 32'(blend(w1, w2, frac[0]));
      r.oor = 1'b0;
    end
    expected_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // driver: presents queued items, with a random gap drawn per item
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_sample(pending_items.pop_front());
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end
      if ((in_valid && !in_stall) || !in_valid) begin
        if (send_gap > 0 || hold_sender || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          in_valid     <= 1'b1;
          operation    <= pending_items[0].op;
          index_x      <= pending_items[0].ix;
          index_y      <= pending_items[0].iy;
          index_z      <= pending_items[0].iz;
          sample_value <= pending_items[0].sval;
          coord_x      <= pending_items[0].cx;
          coord_y      <= pending_items[0].cy;
          coord_z      <= pending_items[0].cz;
        end
      end
    end
  end

  // monitor: random stall per item, compare against oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          if (interp_value !== expected_results[0].val)
            report_mismatch($sformatf("interp_value %h, expected %h",
                                      interp_value, expected_results[0].val));
          if (out_of_range !== expected_results[0].oor)
            report_mismatch($sformatf("out_of_range %b, expected %b",
                                      out_of_range, expected_results[0].oor));
          void'(expected_results.pop_front());
        end
        stall_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted input item, taken result or config write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("trilinear_volume_sampler verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    // a trailing write may still be in flight
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_X_ORIGIN:  origin_q[0] = data;
      REG_Y_ORIGIN:  origin_q[1] = data;
      REG_Z_ORIGIN:  origin_q[2] = data;
      REG_X_INV_LEN: inv_len_q[0] = data[23:0];
      REG_Y_INV_LEN: inv_len_q[1] = data[23:0];
      REG_Z_INV_LEN: inv_len_q[2] = data[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic vol_item_t make_write(input int x, input int y, input int z,
                                           input logic [31:0] v);
    vol_item_t it;
    it = '{default: '0};
    it.op = OP_WRITE;
    it.ix = 5'(x); it.iy = 5'(y); it.iz = 5'(z); it.sval = v;
    return it;
  endfunction

  function automatic vol_item_t make_query(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
    vol_item_t it;
    it = '{default: '0};
    it.op = OP_QUERY;
    it.cx = x; it.cy = y; it.cz = z;
    // junk in the unused fields of a query
    it.ix = 5'($urandom); it.iy = 5'($urandom); it.iz = 5'($urandom); it.sval = $urandom;
    return it;
  endfunction

  // coordinate inside the lattice with identity mapping, sometimes at the edges
  function automatic logic [31:0] inner_coord();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return {16'd30, 16'hffff};
      default: return {11'd0, 5'($urandom_range(0, 30)), 16'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] extreme_val();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // a cluster of writes around a cell, then queries in it
  task automatic queue_cluster();
    int bx, by, bz;
    bx = $urandom_range(0, 30); by = $urandom_range(0, 30); bz = $urandom_range(0, 30);
    for (int k = 0; k < 8; k++)
      pending_items.push_back(make_write(bx + k[2], by + k[1], bz + k[0], extreme_val()));
    for (int k = 0; k < 3; k++)
      pending_items.push_back(make_query({11'd0, 5'(bx), 16'($urandom)},
                                         {11'd0, 5'(by), 16'($urandom)},
                                         {11'd0, 5'(bz), 16'($urandom)}));
  endtask

  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: pending_items.push_back(make_write($urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 31), extreme_val()));
        3:       pending_items.push_back(make_query($urandom, $urandom, $urandom));
        default: pending_items.push_back(make_query(inner_coord(), inner_coord(),
                                                    inner_coord()));
      endcase
    end
  endtask

  initial begin
    foreach (shadow_lattice[k]) shadow_lattice[k] = '0;
    foreach (origin_q[k]) origin_q[k] = '0;
    foreach (inv_len_q[k]) inv_len_q[k] = 24'd65536;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, both operations, range edges
    pending_items.push_back(make_write(0, 0, 0, 32'h7fff_ffff));
    pending_items.push_back(make_write(0, 0, 1, 32'h8000_0000));
    pending_items.push_back(make_write(0, 1, 0, 32'hffff_ffff));
    pending_items.push_back(make_write(1, 1, 1, 32'h0001_0000));
    pending_items.push_back(make_write(31, 31, 31, 32'h1234_5678));
    pending_items.push_back(make_write(30, 30, 30, 32'h8000_0001));
    pending_items.push_back(make_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    pending_items.push_back(make_query(32'h0000_0000, 32'h0000_0000, 32'h0000_ffff));
    pending_items.push_back(make_query(32'h001e_ffff, 32'h001e_ffff, 32'h001e_ffff));
    pending_items.push_back(make_query(32'h001f_0000, 32'h0000_0000, 32'h0000_0000));
    pending_items.push_back(make_query(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000));
    pending_items.push_back(make_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_items.push_back(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(make_query(32'h0000_4000, 32'h0001_c000, 32'h0000_2000));
    wait_drained();

    // several register settings, extremes among them
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_X_ORIGIN, 32'h0000_8000);
          write_reg(REG_Y_ORIGIN, 32'hffff_0000);
          write_reg(REG_Z_ORIGIN, 32'h0000_0000);
        end
        1: begin
          write_reg(REG_X_INV_LEN, 32'h0000_8000);
          write_reg(REG_Y_INV_LEN, 32'h0002_0000);
          write_reg(REG_Z_INV_LEN, 32'h0000_0001);
        end
        2: begin
          write_reg(REG_X_ORIGIN, 32'h7fff_ffff);
          write_reg(REG_Y_ORIGIN, 32'h8000_0000);
          write_reg(REG_Z_INV_LEN, 32'hffff_ffff);
        end
        3: begin
          // back to identity mapping with a small shift
          write_reg(REG_X_ORIGIN, 32'h0000_0000);
          write_reg(REG_Y_ORIGIN, 32'h0000_0000);
          write_reg(REG_Z_ORIGIN, 32'hffff_c000);
          write_reg(REG_X_INV_LEN, 32'h0001_0000);
          write_reg(REG_Y_INV_LEN, 32'h0001_0000);
          write_reg(REG_Z_INV_LEN, 32'h0001_0000);
          write_reg(3'd6, $urandom);
          write_reg(3'd7, $urandom);
        end
        4: begin
          write_reg(REG_X_INV_LEN, 32'h00ff_ffff);
          write_reg(REG_Y_INV_LEN, {8'd0, 24'($urandom_range(1, 24'hffffff))});
          write_reg(REG_Z_ORIGIN, $urandom);
        end
        default: begin
          write_reg(REG_X_ORIGIN, 32'h0);
          write_reg(REG_Y_ORIGIN, 32'h0);
          write_reg(REG_Z_ORIGIN, 32'h0);
          write_reg(REG_X_INV_LEN, 32'h0001_0000);
          write_reg(REG_Y_INV_LEN, 32'h0001_0000);
          write_reg(REG_Z_INV_LEN, 32'h0001_0000);
        end
      endcase
      for (int c = 0; c < 2; c++) queue_cluster();
      queue_random(phase == 5 ? 80 : 40);
      if (phase == 2) begin
        // once part of the items are out, sender holds off until everything has returned
        while (pending_items.size() > 30) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() != 0 || in_valid) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("trilinear_volume_sampler verification clean");
    else
      $display("trilinear_volume_sampler verification failed");
    $finish;
  end

endmodule
